// File: rtl/core/pwra_pkg.sv
package pwra_pkg;

    localparam int NUM_REGS = 16;
    localparam int ADDR_W   = $clog2(NUM_REGS);
    localparam int DATA_W   = 16;
    localparam int REG_W    = 5;
    localparam int NIB_W    = 4;
    localparam int LANES    = DATA_W / NIB_W;

    typedef enum logic [2:0] {
        CMD_MOVE = 3'd0,
        CMD_SWAP = 3'd1,
        CMD_NOT  = 3'd2,
        CMD_AND  = 3'd3,
        CMD_LOAD = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WSRC
    } state_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } rf_wr_t;

    typedef struct packed {
        logic [DATA_W-1:0] nd;
        logic [DATA_W-1:0] ns;
        logic              zero;
    } alu_res_t;

    function automatic logic reg_ok(logic [REG_W-1:0] r);
        return (r != '0) && (r <= REG_W'(NUM_REGS));
    endfunction

    function automatic logic [ADDR_W-1:0] reg_idx(logic [REG_W-1:0] r);
        logic [REG_W-1:0] t;
        t = r - REG_W'(1);
        return t[ADDR_W-1:0];
    endfunction

endpackage

// File: rtl/core/partial_width_register_alu_top.sv
// Channel  Direction  Handshake            Fields
// in       input      in_valid/in_ready    command dest_reg src_reg precision load_value
// out      output     out_valid/out_ready  status dest_value src_value zero_flag busy_cycles
//
// One word at a time: accept, a registered read of the register file, then the
// result is registered; swap adds a second step that writes the source register.
// The single write port of the register file makes that second step necessary.
// Reset clears all registers and the zero flag; no clearing pass is needed.
// A stalled result holds the block in its execute cycle; a finished result
// waiting in the output register does not block the next input word.
module partial_width_register_alu_top
    import pwra_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        command,
    input  logic [REG_W-1:0]  dest_reg,
    input  logic [REG_W-1:0]  src_reg,
    input  logic [1:0]        precision,
    input  logic [DATA_W-1:0] load_value,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              status,
    output logic [DATA_W-1:0] dest_value,
    output logic [DATA_W-1:0] src_value,
    output logic              zero_flag,
    output logic [1:0]        busy_cycles
);

    state_t            state_reg, state_next;
    cmd_t              cmd_reg;
    logic [REG_W-1:0]  rd_reg;
    logic [REG_W-1:0]  rs_reg;
    logic [1:0]        p_reg;
    logic [DATA_W-1:0] imm_reg;
    logic [DATA_W-1:0] ns_reg;
    logic              zero_reg, zero_next;
    logic              out_valid_reg;
    logic              status_reg;
    logic [DATA_W-1:0] dval_reg;
    logic [DATA_W-1:0] sval_reg;
    logic [1:0]        busy_reg;

    logic              rd_en;
    rf_wr_t            wr;
    logic [DATA_W-1:0] d_old;
    logic [DATA_W-1:0] s_old;
    alu_res_t          alu;
    logic              d_ok, s_ok, is_alu, is_load, alu_ok;
    logic              wr_d, wr_s, upd_zero, go;
    logic [DATA_W-1:0] nd;
    logic [DATA_W-1:0] dval_next;
    logic [DATA_W-1:0] sval_next;
    logic              status_next;
    logic [1:0]        busy_next;

    pwra_regfile u_rf (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .raddr_a (reg_idx(dest_reg)),
        .raddr_b (reg_idx(src_reg)),
        .wr      (wr),
        .rdata_a (d_old),
        .rdata_b (s_old)
    );

    pwra_alu u_alu (
        .cmd       (cmd_reg),
        .precision (p_reg),
        .d         (d_old),
        .s         (s_old),
        .res       (alu)
    );

    always_comb
    begin
        d_ok     = reg_ok(rd_reg);
        s_ok     = reg_ok(rs_reg);
        is_load  = (cmd_reg == CMD_LOAD);
        is_alu   = (cmd_reg == CMD_MOVE) || (cmd_reg == CMD_SWAP) ||
                   (cmd_reg == CMD_NOT)  || (cmd_reg == CMD_AND);
        alu_ok   = is_alu && d_ok && s_ok;
        wr_d     = (is_load && d_ok) || alu_ok;
        wr_s     = alu_ok && (cmd_reg == CMD_SWAP);
        upd_zero = alu_ok && ((cmd_reg == CMD_NOT) || (cmd_reg == CMD_AND));
        nd       = is_load ? imm_reg : alu.nd;
        zero_next = upd_zero ? alu.zero : zero_reg;

        status_next = (is_load && !d_ok) || (is_alu && !alu_ok);
        busy_next   = alu_ok ? p_reg : 2'd0;

        dval_next = '0;
        if (d_ok)
        begin
            dval_next = wr_d ? nd : d_old;
        end
        sval_next = '0;
        if (s_ok)
        begin
            if (wr_d && (rs_reg == rd_reg))
            begin
                sval_next = nd;
            end
            else if (wr_s)
            begin
                sval_next = alu.ns;
            end
            else
            begin
                sval_next = s_old;
            end
        end
        go = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (go)
                begin
                    state_next = wr_s ? ST_WSRC : ST_IDLE;
                end
            end
            ST_WSRC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        rd_en    = 1'b0;
        wr       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                rd_en    = in_valid;
            end
            ST_EXEC:
            begin
                wr.en   = go && wr_d;
                wr.addr = reg_idx(rd_reg);
                wr.data = nd;
            end
            ST_WSRC:
            begin
                wr.en   = 1'b1;
                wr.addr = reg_idx(rs_reg);
                wr.data = ns_reg;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            zero_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_EXEC && go)
            begin
                zero_reg      <= zero_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg <= cmd_t'(command);
            rd_reg  <= dest_reg;
            rs_reg  <= src_reg;
            p_reg   <= precision;
            imm_reg <= load_value;
        end
        if (state_reg == ST_EXEC && go)
        begin
            ns_reg     <= alu.ns;
            status_reg <= status_next;
            dval_reg   <= dval_next;
            sval_reg   <= sval_next;
            busy_reg   <= busy_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign dest_value  = dval_reg;
    assign src_value   = sval_reg;
    assign zero_flag   = zero_reg;
    assign busy_cycles = busy_reg;

`ifndef SYNTHESIS
    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == ST_EXEC)
        else $error("accepted word did not enter execute");

    a_wsrc_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WSRC |-> $past(state_reg) == ST_EXEC)
        else $error("source write not preceded by execute");

    a_wsrc_swap_only: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WSRC |-> cmd_reg == CMD_SWAP)
        else $error("second write for a non-swap word");

    a_status_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg |-> busy_reg == 2'd0)
        else $error("failed word reports nonzero busy");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !wr.en)
        else $error("register file write while idle");
`endif

endmodule

// File: rtl/core/pwra_regfile.sv
module pwra_regfile
    import pwra_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] raddr_a,
    input  logic [ADDR_W-1:0] raddr_b,
    input  rf_wr_t            wr,
    output logic [DATA_W-1:0] rdata_a,
    output logic [DATA_W-1:0] rdata_b
);

    logic [DATA_W-1:0]   mem [NUM_REGS];
    logic [DATA_W-1:0]   qa_reg;
    logic [DATA_W-1:0]   qb_reg;
    logic [NUM_REGS-1:0] vld_reg;
    logic                va_reg;
    logic                vb_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            qa_reg <= mem[raddr_a];
            qb_reg <= mem[raddr_b];
        end
    end

    // entries never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            va_reg  <= 1'b0;
            vb_reg  <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                vld_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                va_reg <= vld_reg[raddr_a];
                vb_reg <= vld_reg[raddr_b];
            end
        end
    end

    assign rdata_a = va_reg ? qa_reg : '0;
    assign rdata_b = vb_reg ? qb_reg : '0;

endmodule

// File: rtl/core/pwra_alu.sv
module pwra_alu
    import pwra_pkg::*;
(
    input  cmd_t              cmd,
    input  logic [1:0]        precision,
    input  logic [DATA_W-1:0] d,
    input  logic [DATA_W-1:0] s,
    output alu_res_t          res
);

    logic [DATA_W-1:0] lanes;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            lanes[i*NIB_W +: NIB_W] = (i <= int'(precision)) ? '1 : '0;
        end
    end

    always_comb
    begin
        res.ns = (s & ~lanes) | (d & lanes);
        case (cmd) inside
            CMD_MOVE, CMD_SWAP: res.nd = (d & ~lanes) | (s & lanes);
            CMD_NOT:            res.nd = (d & ~lanes) | (~s & lanes);
            CMD_AND:            res.nd = (d & ~lanes) | (d & s & lanes);
            default:            res.nd = d;
        endcase
        res.zero = ((res.nd & lanes) == '0);
    end

endmodule

// File: dv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pwra_pkg::*;

    localparam logic [2:0]       CMD_BAD_FIRST = 3'd5;
    localparam logic [2:0]       CMD_BAD_MID   = 3'd6;
    localparam logic [2:0]       CMD_BAD_LAST  = 3'd7;
    localparam logic [REG_W-1:0] REG_NONE      = '0;
    localparam logic [REG_W-1:0] REG_TOP       = '1;
    localparam int               TX_GAP_DEF    = 11;
    localparam int               RX_STALL_DEF  = 11;
    localparam int               LONG_HOLD     = 300;

    typedef struct packed {
        logic              status;
        logic [DATA_W-1:0] dest_value;
        logic [DATA_W-1:0] src_value;
        logic              zero_flag;
        logic [1:0]        busy_cycles;
    } alu_word_t;

    logic              clk;
    logic              rst_n      = 1'b0;
    logic              in_valid   = 1'b0;
    logic              in_ready;
    logic [2:0]        command    = '0;
    logic [REG_W-1:0]  dest_reg   = '0;
    logic [REG_W-1:0]  src_reg    = '0;
    logic [1:0]        precision  = '0;
    logic [DATA_W-1:0] load_value = '0;
    logic              out_valid;
    logic              out_ready  = 1'b0;
    logic              status;
    logic [DATA_W-1:0] dest_value;
    logic [DATA_W-1:0] src_value;
    logic              zero_flag;
    logic [1:0]        busy_cycles;

    // shadow of the block's architectural state
    logic [DATA_W-1:0] shadow_regs [1:NUM_REGS];
    logic              shadow_zero;

    alu_word_t expected_words [$];
    int        mismatches      = 0;
    int        tx_gap_max      = TX_GAP_DEF;
    int        rx_stall_max    = RX_STALL_DEF;
    int        hold_off_cycles = 0;

    partial_width_register_alu_top dut (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic reg_valid(logic [REG_W-1:0] r);
        return (r >= 1) && (r <= NUM_REGS);
    endfunction

    function automatic logic [DATA_W-1:0] shadow_read(logic [REG_W-1:0] r);
        return reg_valid(r) ? shadow_regs[r] : '0;
    endfunction

    function automatic alu_word_t execute_instr(logic [2:0] cmd, logic [REG_W-1:0] rd,
                                                logic [REG_W-1:0] rs, logic [1:0] p,
                                                logic [DATA_W-1:0] imm);
        alu_word_t         res;
        logic [DATA_W-1:0] lanes;
        logic [DATA_W-1:0] d;
        logic [DATA_W-1:0] s;
        logic [DATA_W-1:0] nd;
        lanes = 16'hffff >> (NIB_W * (3 - int'(p)));
        res   = '0;
        if (cmd == CMD_LOAD)
        begin
            if (reg_valid(rd))
                shadow_regs[rd] = imm;
            else
                res.status = 1'b1;
        end
        else if (cmd <= CMD_AND)
        begin
            if (!reg_valid(rd) || !reg_valid(rs))
                res.status = 1'b1;
            else
            begin
                d  = shadow_regs[rd];
                s  = shadow_regs[rs];
                nd = d;
                case (cmd)
                    CMD_MOVE: nd = (d & ~lanes) | (s & lanes);
                    CMD_SWAP:
                    begin
                        nd = (d & ~lanes) | (s & lanes);
                        shadow_regs[rs] = (s & ~lanes) | (d & lanes);
                    end
                    CMD_NOT:  nd = (d & ~lanes) | (~s & lanes);
                    default:  nd = (d & ~lanes) | (d & s & lanes);
                endcase
                shadow_regs[rd] = nd;
                if (cmd == CMD_NOT || cmd == CMD_AND)
                    shadow_zero = ((nd & lanes) == '0);
                res.busy_cycles = p;
            end
        end
        res.dest_value = shadow_read(rd);
        res.src_value  = shadow_read(rs);
        res.zero_flag  = shadow_zero;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                   logic [DATA_W-1:0] exp);
        mismatches++;
        $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, exp);
    endtask

    task automatic send_word(logic [2:0] cmd, logic [REG_W-1:0] rd, logic [REG_W-1:0] rs,
                             logic [1:0] p, logic [DATA_W-1:0] imm);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        command    <= cmd;
        dest_reg   <= rd;
        src_reg    <= rs;
        precision  <= p;
        load_value <= imm;
        do @(posedge clk); while (!in_ready);
        expected_words.push_back(execute_instr(cmd, rd, rs, p, imm));
    endtask

    function automatic logic [REG_W-1:0] pick_reg();
        if ($urandom_range(0, 99) < 92)
            return REG_W'($urandom_range(1, NUM_REGS));
        if ($urandom_range(0, 1) == 0)
            return REG_NONE;
        return REG_W'($urandom_range(NUM_REGS + 1, int'(REG_TOP)));
    endfunction

    task automatic send_random_word();
        int                pick;
        logic [2:0]        cmd;
        logic [REG_W-1:0]  rd;
        logic [REG_W-1:0]  rs;
        logic [DATA_W-1:0] imm;
        pick = $urandom_range(0, 99);
        if (pick < 20)
            cmd = CMD_LOAD;
        else if (pick < 97)
            cmd = 3'($urandom_range(CMD_MOVE, CMD_AND));
        else
            cmd = 3'($urandom_range(CMD_BAD_FIRST, CMD_BAD_LAST));
        rd = pick_reg();
        rs = ($urandom_range(0, 9) == 0) ? rd : pick_reg();
        case ($urandom_range(0, 7))
            0:       imm = '0;
            1:       imm = '1;
            default: imm = DATA_W'($urandom);
        endcase
        send_word(cmd, rd, rs, 2'($urandom_range(0, 3)), imm);
    endtask

    task automatic test_directed();
        send_word(CMD_LOAD, 5'd1,  5'd2,  2'd0, 16'hffff);
        send_word(CMD_LOAD, 5'd16, 5'd1,  2'd3, 16'h0000);
        send_word(CMD_LOAD, 5'd2,  5'd16, 2'd1, 16'h1234);
        send_word(CMD_LOAD, 5'd3,  5'd1,  2'd2, 16'ha5a5);
        send_word(CMD_MOVE, 5'd16, 5'd1,  2'd0, 16'h0000);
        send_word(CMD_MOVE, 5'd16, 5'd3,  2'd3, 16'h0000);
        send_word(CMD_SWAP, 5'd2,  5'd3,  2'd1, 16'h0000);
        send_word(CMD_SWAP, 5'd1,  5'd16, 2'd2, 16'h0000);
        send_word(CMD_LOAD, 5'd1,  5'd1,  2'd0, 16'hffff);
        // NOT of all ones over full width: zero flag rises
        send_word(CMD_NOT,  5'd4,  5'd1,  2'd3, 16'h0000);
        send_word(CMD_NOT,  5'd5,  5'd16, 2'd0, 16'h0000);
        send_word(CMD_AND,  5'd3,  5'd2,  2'd2, 16'h0000);
        send_word(CMD_AND,  5'd5,  5'd4,  2'd3, 16'h0000);
        // same register as source and destination
        send_word(CMD_MOVE, 5'd7,  5'd7,  2'd1, 16'h0000);
        send_word(CMD_SWAP, 5'd2,  5'd2,  2'd3, 16'h0000);
        send_word(CMD_AND,  5'd1,  5'd1,  2'd0, 16'h0000);
        send_word(CMD_NOT,  5'd3,  5'd3,  2'd1, 16'h0000);
        // out-of-range register numbers
        send_word(CMD_MOVE, REG_NONE, 5'd1, 2'd2, 16'h0000);
        send_word(CMD_SWAP, 5'd2, 5'd17, 2'd3, 16'h0000);
        send_word(CMD_NOT,  REG_TOP, REG_TOP, 2'd3, 16'hffff);
        send_word(CMD_LOAD, REG_NONE, 5'd3, 2'd3, 16'hffff);
        send_word(CMD_LOAD, 5'd6, REG_TOP, 2'd0, 16'h0000);
        // undefined opcodes
        send_word(CMD_BAD_FIRST, 5'd1, 5'd3, 2'd3, 16'hffff);
        send_word(CMD_BAD_LAST,  5'd16, 5'd2, 2'd1, 16'h0000);
        send_word(CMD_BAD_MID, REG_NONE, REG_TOP, 2'd2, 16'h5a5a);
    endtask

    task automatic test_random();
        repeat (1400) send_random_word();
    endtask

    task automatic test_back_to_back();
        tx_gap_max   = 0;
        rx_stall_max = 0;
        repeat (100) send_random_word();
        tx_gap_max   = TX_GAP_DEF;
        rx_stall_max = RX_STALL_DEF;
    endtask

    task automatic test_output_stall();
        tx_gap_max      = 0;
        hold_off_cycles = LONG_HOLD;
        repeat (50) send_random_word();
        tx_gap_max      = TX_GAP_DEF;
    endtask

    task automatic drain_and_finish();
        in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    endtask

    initial
    begin
        for (int i = 1; i <= NUM_REGS; i++)
            shadow_regs[i] = '0;
        shadow_zero = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random();
        test_back_to_back();
        test_output_stall();
        drain_and_finish();
    end

    // result sink: random stalls, one long hold-off on request
    initial
    begin : result_sink
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = (hold_off_cycles > 0) ? hold_off_cycles : $urandom_range(0, rx_stall_max);
            hold_off_cycles = 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        alu_word_t exp;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_words.size() == 0)
                report_mismatch("unexpected word", dest_value, '0);
            else
            begin
                exp = expected_words.pop_front();
                if (status !== exp.status)
                    report_mismatch("status", DATA_W'(status), DATA_W'(exp.status));
                if (dest_value !== exp.dest_value)
                    report_mismatch("dest_value", dest_value, exp.dest_value);
                if (src_value !== exp.src_value)
                    report_mismatch("src_value", src_value, exp.src_value);
                if (zero_flag !== exp.zero_flag)
                    report_mismatch("zero_flag", DATA_W'(zero_flag), DATA_W'(exp.zero_flag));
                if (busy_cycles !== exp.busy_cycles)
                    report_mismatch("busy_cycles", DATA_W'(busy_cycles),
                                    DATA_W'(exp.busy_cycles));
            end
        end
    end

    initial
    begin
        #3ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
